/* sv/clr_pkg.sv */
// ----------------------------------------------------------------------------
// clr_pkg
// Shared types and constants for the clipped line rasteriser: default screen
// geometry, frame store word layout, operation codes and status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package clr_pkg;

  // Default geometry, handed to the top-level parameters.
  localparam int SCREEN_WIDTH_DEF  = 320;
  localparam int SCREEN_HEIGHT_DEF = 200;
  localparam int COORD_BITS_DEF    = 12;

  // The frame store packs this many one-bit pixels into each memory word.
  localparam int PIXELS_PER_WORD = 16;

  // Byte returned for a set pixel.
  localparam logic [7:0] PIXEL_ON  = 8'd255;
  localparam logic [7:0] PIXEL_OFF = 8'd0;

  // Operation carried by an input item.
  typedef enum logic {
    OP_DRAW = 1'b0,
    OP_READ = 1'b1
  } op_t;

  // Sequencer states of the top level.
  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_DRAW   = 6'b000010,
    ST_DRAIN  = 6'b000100,
    ST_RD_REQ = 6'b001000,
    ST_RD_WT  = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  // Status reported by the frame store to the sequencer.
  typedef struct packed {
    logic clearing;  // reset clearing pass in progress
    logic busy;      // an access is still in the pipeline
    logic rd_done;   // a pixel read completes this cycle
    logic rd_bit;    // value of that pixel
  } fb_status_t;

endpackage

`default_nettype wire

/* sv/clr_channels.sv */
// ----------------------------------------------------------------------------
// clr_channels
// Valid/ready channel interfaces: the input item channel and the result
// channel of the line rasteriser.
// ----------------------------------------------------------------------------
`default_nettype none

interface clr_in_if #(
  parameter int COORD_BITS = 12
);
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic signed [COORD_BITS-1:0] x_start;
  logic signed [COORD_BITS-1:0] y_start;
  logic signed [COORD_BITS-1:0] x_end;
  logic signed [COORD_BITS-1:0] y_end;

  modport source (output valid, opcode, x_start, y_start, x_end, y_end, input ready);
  modport sink   (input valid, opcode, x_start, y_start, x_end, y_end, output ready);
endinterface

interface clr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_value;
  logic       completed_opcode;

  modport source (output valid, read_value, completed_opcode, input ready);
  modport sink   (input valid, read_value, completed_opcode, output ready);
endinterface

`default_nettype wire

/* sv/clr_walker.sv */
// ----------------------------------------------------------------------------
// clr_walker
// Bresenham stepper. Loaded with two endpoints, it presents one visited
// pixel per cycle, marking the final pixel, which is always the end point.
// ----------------------------------------------------------------------------
`default_nettype none

module clr_walker #(
  parameter int COORD_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [COORD_BITS-1:0] x_start,
  input  logic signed [COORD_BITS-1:0] y_start,
  input  logic signed [COORD_BITS-1:0] x_end,
  input  logic signed [COORD_BITS-1:0] y_end,
  output logic                         pix_valid,
  output logic                         pix_last,
  output logic signed [COORD_BITS-1:0] pix_x,
  output logic signed [COORD_BITS-1:0] pix_y
);
  import clr_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int EW = COORD_BITS + 3;

  logic                 active_r;
  logic signed [CB-1:0] x_r, y_r, xe_r, ye_r;
  logic [CB-1:0]        dx_r, dy_r;
  logic                 sx_neg_r, sy_neg_r;
  logic signed [EW-1:0] err_r;

  logic signed [CB:0]   ddx, ddy, adx, ady;
  logic [CB-1:0]        dx_init, dy_init;
  logic signed [EW-1:0] err_init, err_nxt;
  logic signed [EW:0]   e2, ndy, pdx;
  logic                 at_end, step_x, step_y;

  // Set-up: absolute deltas, directions and initial error term.
  always_comb begin
    ddx      = {x_end[CB-1], x_end} - {x_start[CB-1], x_start};
    ddy      = {y_end[CB-1], y_end} - {y_start[CB-1], y_start};
    adx      = ddx[CB] ? -ddx : ddx;
    ady      = ddy[CB] ? -ddy : ddy;
    dx_init  = adx[CB-1:0];
    dy_init  = ady[CB-1:0];
    err_init = $signed({3'b000, dx_init}) - $signed({3'b000, dy_init});
  end

  // One Bresenham step: doubled error compared against -dy and dx.
  always_comb begin
    at_end  = (x_r == xe_r) && (y_r == ye_r);
    e2      = {err_r, 1'b0};
    ndy     = -$signed({4'b0000, dy_r});
    pdx     = $signed({4'b0000, dx_r});
    step_x  = e2 > ndy;
    step_y  = e2 < pdx;
    err_nxt = err_r - (step_x ? $signed({3'b000, dy_r}) : EW'(0))
                    + (step_y ? $signed({3'b000, dx_r}) : EW'(0));
  end

  // Walk state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (start) begin
      active_r <= 1'b1;
    end else if (active_r && at_end) begin
      active_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r      <= x_start;
      y_r      <= y_start;
      xe_r     <= x_end;
      ye_r     <= y_end;
      dx_r     <= dx_init;
      dy_r     <= dy_init;
      sx_neg_r <= !(x_start < x_end);
      sy_neg_r <= !(y_start < y_end);
      err_r    <= err_init;
    end else if (active_r && !at_end) begin
      err_r <= err_nxt;
      if (step_x) begin
        x_r <= sx_neg_r ? x_r - CB'(1) : x_r + CB'(1);
      end
      if (step_y) begin
        y_r <= sy_neg_r ? y_r - CB'(1) : y_r + CB'(1);
      end
    end
  end

  assign pix_valid = active_r;
  assign pix_last  = active_r && at_end;
  assign pix_x     = x_r;
  assign pix_y     = y_r;

endmodule

`default_nettype wire

/* sv/clr_frame_store.sv */
// ----------------------------------------------------------------------------
// clr_frame_store
// One-bit frame store packed into words in a synchronous memory. Pixel
// writes are read-modify-write over a two-stage pipeline with forwarding of
// the last written word; pixel reads use the same path. A clearing pass
// zeroes every word after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module clr_frame_store #(
  parameter int SCREEN_WIDTH  = clr_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = clr_pkg::SCREEN_HEIGHT_DEF,
  parameter int COORD_BITS    = clr_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         req_valid,
  input  logic                         req_rd,
  input  logic signed [COORD_BITS-1:0] req_x,
  input  logic signed [COORD_BITS-1:0] req_y,
  output clr_pkg::fb_status_t          status
);
  import clr_pkg::*;

  localparam int PIXELS = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int DEPTH  = (PIXELS + PIXELS_PER_WORD - 1) / PIXELS_PER_WORD;
  localparam int WAW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int BSW    = $clog2(PIXELS_PER_WORD);
  localparam int IW     = WAW + BSW;
  localparam int CB     = COORD_BITS;

  logic [PIXELS_PER_WORD-1:0] frame_mem [DEPTH];

  logic                       clearing_r;
  logic [WAW-1:0]             clr_cnt_r;
  logic                       s1_valid_r, s1_rd_r, s1_on_r;
  logic [WAW-1:0]             s1_word_r;
  logic [BSW-1:0]             s1_bit_r;
  logic                       s2_valid_r, s2_rd_r, s2_on_r;
  logic [WAW-1:0]             s2_word_r;
  logic [BSW-1:0]             s2_bit_r;
  logic [PIXELS_PER_WORD-1:0] rdata_r;
  logic                       last_valid_r;
  logic [WAW-1:0]             last_word_r;
  logic [PIXELS_PER_WORD-1:0] last_data_r;

  logic                       on_screen;
  logic [IW-1:0]              pix_idx;
  logic                       fwd, s2_wr, mem_we;
  logic [PIXELS_PER_WORD-1:0] cur_word, merged, mem_wd;
  logic [WAW-1:0]             mem_wa;

  // Stage 0: screen test and linear pixel index.
  always_comb begin
    on_screen = !req_x[CB-1] && !req_y[CB-1]
             && (32'($unsigned(req_x)) < 32'(SCREEN_WIDTH))
             && (32'($unsigned(req_y)) < 32'(SCREEN_HEIGHT));
    pix_idx   = IW'($unsigned(req_y)) * IW'(SCREEN_WIDTH) + IW'($unsigned(req_x));
  end

  // Reset clearing pass, one word per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      if (clr_cnt_r == WAW'(DEPTH - 1)) begin
        clearing_r <= 1'b0;
      end else begin
        clr_cnt_r <= clr_cnt_r + WAW'(1);
      end
    end
  end

  // Pipeline control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= req_valid && !clearing_r;
      s2_valid_r <= s1_valid_r;
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    s1_rd_r   <= req_rd;
    s1_on_r   <= on_screen;
    s1_word_r <= pix_idx[BSW +: WAW];
    s1_bit_r  <= pix_idx[BSW-1:0];
    s2_rd_r   <= s1_rd_r;
    s2_on_r   <= s1_on_r;
    s2_word_r <= s1_word_r;
    s2_bit_r  <= s1_bit_r;
  end

  // Stage 2: merge with the last written word when it is the same word, as the read may have missed it.
  always_comb begin
    fwd      = last_valid_r && (last_word_r == s2_word_r);
    cur_word = fwd ? last_data_r : rdata_r;
    merged   = cur_word | (PIXELS_PER_WORD'(1) << s2_bit_r);
    s2_wr    = s2_valid_r && !s2_rd_r && s2_on_r;
    mem_we   = clearing_r || s2_wr;
    mem_wa   = clearing_r ? clr_cnt_r : s2_word_r;
    mem_wd   = clearing_r ? '0 : merged;
  end

  // Memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[mem_wa] <= mem_wd;
    end
    rdata_r <= frame_mem[s1_word_r];
  end

  // Most recent pixel write, kept for forwarding.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_valid_r <= 1'b0;
    end else if (s2_wr) begin
      last_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_wr) begin
      last_word_r <= s2_word_r;
      last_data_r <= merged;
    end
  end

  always_comb begin
    status.clearing = clearing_r;
    status.busy     = s1_valid_r || s2_valid_r;
    status.rd_done  = s2_valid_r && s2_rd_r;
    status.rd_bit   = s2_on_r && cur_word[s2_bit_r];
  end

endmodule

`default_nettype wire

/* sv/clipped_line_rasterizer.sv */
// ----------------------------------------------------------------------------
// clipped_line_rasterizer
// Bresenham line engine over a one-bit frame store, with pixel read-back.
// ----------------------------------------------------------------------------
// After reset the frame store is zeroed by a clearing pass over
// ceil(SCREEN_WIDTH*SCREEN_HEIGHT/16) words (4000 with the default 320x200
// screen), during which no item is accepted. Items are then handled one at a
// time. A draw walks one pixel per cycle over max(|dx|,|dy|) + 1 pixels,
// then drains the read-modify-write pipeline of the frame store memory and
// posts the result; a read goes through the memory's registered read port.
// A finished result is held in an output register, so the next item may be
// accepted while it waits.
// ----------------------------------------------------------------------------
`default_nettype none

module clipped_line_rasterizer #(
  parameter int SCREEN_WIDTH  = clr_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = clr_pkg::SCREEN_HEIGHT_DEF,
  parameter int COORD_BITS    = clr_pkg::COORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  clr_in_if.sink    in_chan,
  clr_out_if.source out_chan
);
  import clr_pkg::*;

  localparam int CB = COORD_BITS;

  state_t               state_r, state_nxt;
  logic signed [CB-1:0] rd_x_r, rd_y_r;
  logic                 res_op_r;
  logic [7:0]           res_value_r;
  logic                 out_valid_r;
  logic [7:0]           out_value_r;
  logic                 out_op_r;

  logic                 in_xfer, out_free, walk_start;
  logic                 pix_valid, pix_last;
  logic signed [CB-1:0] pix_x, pix_y;
  logic                 req_valid, req_rd;
  logic signed [CB-1:0] req_x, req_y;
  fb_status_t           fb_status;

  assign in_chan.ready = (state_r == ST_IDLE) && !fb_status.clearing;
  assign in_xfer       = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;
  assign walk_start    = in_xfer && (in_chan.opcode == OP_DRAW);

  // Line stepper.
  clr_walker #(
    .COORD_BITS (COORD_BITS)
  ) u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (walk_start),
    .x_start   (in_chan.x_start),
    .y_start   (in_chan.y_start),
    .x_end     (in_chan.x_end),
    .y_end     (in_chan.y_end),
    .pix_valid (pix_valid),
    .pix_last  (pix_last),
    .pix_x     (pix_x),
    .pix_y     (pix_y)
  );

  // Frame store requests: walked pixels while drawing, one read in ST_RD_REQ.
  always_comb begin
    req_valid = ((state_r == ST_DRAW) && pix_valid) || (state_r == ST_RD_REQ);
    req_rd    = (state_r == ST_RD_REQ);
    req_x     = (state_r == ST_RD_REQ) ? rd_x_r : pix_x;
    req_y     = (state_r == ST_RD_REQ) ? rd_y_r : pix_y;
  end

  clr_frame_store #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .COORD_BITS    (COORD_BITS)
  ) u_frame_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_rd    (req_rd),
    .req_x     (req_x),
    .req_y     (req_y),
    .status    (fb_status)
  );

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = (in_chan.opcode == OP_READ) ? ST_RD_REQ : ST_DRAW;
        end
      end
      ST_DRAW: begin
        if (pix_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!fb_status.busy) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_RD_REQ: begin
        state_nxt = ST_RD_WT;
      end
      ST_RD_WT: begin
        if (fb_status.rd_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Item capture and pending result.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      rd_x_r <= in_chan.x_start;
      rd_y_r <= in_chan.y_start;
    end
    if ((state_r == ST_DRAIN) && !fb_status.busy) begin
      res_op_r    <= OP_DRAW;
      res_value_r <= PIXEL_OFF;
    end else if ((state_r == ST_RD_WT) && fb_status.rd_done) begin
      res_op_r    <= OP_READ;
      res_value_r <= fb_status.rd_bit ? PIXEL_ON : PIXEL_OFF;
    end
  end

  // Output register: loaded when the slot is free, cleared on transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_FINISH) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_FINISH) && out_free) begin
      out_value_r <= res_value_r;
      out_op_r    <= res_op_r;
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.read_value       = out_value_r;
  assign out_chan.completed_opcode = out_op_r;

endmodule

`default_nettype wire

/* sv/clr_checker.sv */
// ----------------------------------------------------------------------------
// clr_checker
// Port-level checks of the line rasteriser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module clr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] read_value,
  input logic       completed_opcode
);
  import clr_pkg::*;

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(read_value)
                                && $stable(completed_opcode))
    else $error("result changed while stalled");

  // A draw always reports a zero byte.
  a_draw_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (completed_opcode == OP_DRAW) |-> read_value == PIXEL_OFF)
    else $error("draw result carries a non-zero byte");

  // A pixel byte is either fully on or fully off.
  a_value_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (read_value == PIXEL_OFF) || (read_value == PIXEL_ON))
    else $error("pixel byte is neither on nor off");

  // Items are worked on one at a time: after a transfer the input stalls.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in progress");

endmodule

bind clipped_line_rasterizer clr_checker u_clr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_chan.valid),
  .in_ready         (in_chan.ready),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .read_value       (out_chan.read_value),
  .completed_opcode (out_chan.completed_opcode)
);

`default_nettype wire
